// File: hw/rtl/positional_list_engine_macros.svh
// Assertion macros used by the checker file of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define PLE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list engine: assertion failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define PLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list engine: assertion failed");

`endif

// File: hw/rtl/ple_pkg.sv
// Package: sizes, operation and status codes, controller command type.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = 5;
	localparam int POS_W      = 5;
	localparam int OP_W       = 3;
	localparam int STAT_W     = 2;

	localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT      = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ        = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic load;   // capture the request beat
		logic exec;   // apply the captured request and register its result
	} cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/ple_req_if.sv
// Request channel: valid/ready with operation, position and data word.
`timescale 1ns / 1ps
`default_nettype none

interface ple_req_if;
	import ple_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [POS_W-1:0]      position;
	logic [DATA_WIDTH-1:0] data_in;

	modport source (output valid, output operation, output position, output data_in,
		input ready);
	modport sink (input valid, input operation, input position, input data_in,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ple_rsp_if.sv
// Response channel: valid/ready with data word, status and count.
`timescale 1ns / 1ps
`default_nettype none

interface ple_rsp_if;
	import ple_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] data_out;
	logic [STAT_W-1:0]     status;
	logic [CNT_W-1:0]      count;

	modport source (output valid, output data_out, output status, output count,
		input ready);
	modport sink (input valid, input data_out, input status, input count,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: controller plus datapath.
//
//  channel  modport        payload                          beat
//  req      ple_req_if     operation, position, data_in     valid & ready
//  rsp      ple_rsp_if     data_out, status, count          valid & ready
//
// A request is first captured in the request register, then executed: all
// cells shift in parallel and the result register loads. The single request
// register takes no new request until the previous one has executed.
// A new request is taken while the previous response still waits; execute
// holds until the response register is free. Reset clears the count and the
// handshake; cell contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);
	import ple_pkg::*;

	cmd_t cmd;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	ple_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (req.operation),
		.position  (req.position),
		.data_in   (req.data_in),
		.data_out  (rsp.data_out),
		.status    (rsp.status),
		.count     (rsp.count)
	);
endmodule

`default_nettype wire

// File: hw/rtl/ple_ctrl.sv
// Controller: request capture, execute sequencing and response valid.
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output ple_pkg::cmd_t    cmd
);
	import ple_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic exec_ok;

	assign req_ready = (state_q == ST_IDLE);
	// the result register may be overwritten once its beat is gone or leaves now
	assign exec_ok   = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cmd.load = req_valid && req_ready;
		cmd.exec = exec_ok;
	end

	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_ok) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end
endmodule

`default_nettype wire

// File: hw/rtl/ple_datapath.sv
// Datapath: request register, shifting cell array, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module ple_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ple_pkg::cmd_t                  cmd,
	input  wire logic [ple_pkg::OP_W-1:0]       operation,
	input  wire logic [ple_pkg::POS_W-1:0]      position,
	input  wire logic [ple_pkg::DATA_WIDTH-1:0] data_in,
	output logic      [ple_pkg::DATA_WIDTH-1:0] data_out,
	output logic      [ple_pkg::STAT_W-1:0]     status,
	output logic      [ple_pkg::CNT_W-1:0]      count
);
	import ple_pkg::*;

	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	word_t             data_q;

	word_t             cells_q [CAPACITY];
	logic [CNT_W-1:0]  cnt_q;

	word_t             data_out_q;
	logic [STAT_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;

	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  last;
	logic [CNT_W-1:0]  ipos;
	logic [CNT_W-1:0]  rpos;
	logic              do_ins;
	logic              do_rem;
	logic [STAT_W-1:0] stat;
	word_t             word;
	logic [CNT_W-1:0]  cnt_next;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			pos_q  <= position;
			data_q <= data_in;
		end
	end

	assign full  = (cnt_q == CAP_COUNT);
	assign empty = (cnt_q == '0);
	assign last  = cnt_q - CNT_W'(1);
	// positions past the end clamp to the append slot / last word
	assign ipos  = (op_q == OP_APPEND || pos_q > cnt_q) ? cnt_q : pos_q;
	assign rpos  = (op_q == OP_REMOVE_LAST || pos_q > last) ? last : pos_q;

	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		stat   = ST_OK;
		word   = '0;
		case (op_q)
			OP_APPEND, OP_INSERT: begin
				if (full) stat = ST_FULL;
				else do_ins = 1'b1;
			end
			OP_REMOVE_LAST, OP_REMOVE_AT: begin
				if (empty) begin
					stat = ST_EMPTY;
				end else begin
					do_rem = 1'b1;
					word   = cells_q[rpos[IDX_W-1:0]];
				end
			end
			OP_READ: begin
				if (empty) stat = ST_EMPTY;
				else if (pos_q >= cnt_q) stat = ST_RANGE;
				else word = cells_q[pos_q[IDX_W-1:0]];
			end
			default: stat = ST_RANGE;
		endcase
	end

	always_comb begin
		cnt_next = cnt_q;
		if (do_ins) cnt_next = cnt_q + CNT_W'(1);
		else if (do_rem) cnt_next = cnt_q - CNT_W'(1);
	end

	// all cells from the slot upward move in the same cycle: up on insert, down on remove
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_ins) begin
					if (CNT_W'(g) == ipos) begin
						cells_q[g] <= data_q;
					end else if (CNT_W'(g) > ipos) begin
						if (g > 0) cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
					end
				end else if (do_rem && CNT_W'(g) >= rpos) begin
					if (g < CAPACITY - 1)
						cells_q[g] <= cells_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			data_out_q <= word;
			status_q   <= stat;
			count_q    <= cnt_next;
		end
	end

	assign data_out = data_out_q;
	assign status   = status_q;
	assign count    = count_q;
endmodule

`default_nettype wire

// File: hw/rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_macros.svh"

module ple_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [ple_pkg::DATA_WIDTH-1:0] data_out,
	input wire logic [ple_pkg::STAT_W-1:0]     status,
	input wire logic [ple_pkg::CNT_W-1:0]      count
);
	import ple_pkg::*;

	logic rsp_stall;

	assign rsp_stall = rsp_valid && !rsp_ready;

	// a stalled response beat holds
	`PLE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({data_out, status, count}))
	`PLE_ASSERT_NOW(a_err_zero, rsp_valid && status != ST_OK, data_out == '0)
	`PLE_ASSERT_NOW(a_full_cnt, rsp_valid && status == ST_FULL, count == CAP_COUNT)
	`PLE_ASSERT_NOW(a_empty_cnt, rsp_valid && status == ST_EMPTY, count == '0)
endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.data_out  (rsp.data_out),
	.status    (rsp.status),
	.count     (rsp.count)
);

`default_nettype wire
